>>> sv/rtca_pkg.sv
// Package for the real-time counter with alarm.
// Holds register offsets, mode and status bit positions and the item types.
// Used by the stage, core and top-level files of the block.
`timescale 1ns / 1ps

package rtca_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_IDLE  = 2'd3;

  localparam logic [4:0] OFF_MODE   = 5'h00;
  localparam logic [4:0] OFF_ALARM  = 5'h04;
  localparam logic [4:0] OFF_VALUE  = 5'h08;
  localparam logic [4:0] OFF_STATUS = 5'h0c;

  // Counter reset bit (0x40000) of the mode word.
  localparam int unsigned MODE_CNT_RESET_BIT = 18;

  localparam int unsigned STAT_ALARM_BIT = 0;
  localparam int unsigned STAT_INC_BIT   = 1;

  localparam logic [31:0] MODE_RESET  = 32'h0000_8000;
  localparam logic [31:0] ALARM_RESET = 32'hffff_ffff;

  typedef struct packed {
    logic [1:0]  op;
    logic [4:0]  offset;
    logic [31:0] write_data;
  } rtca_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic        bad_access;
  } rtca_result_t;

endpackage

>>> sv/rtca_ifs.sv
// Channel interfaces of the real-time counter with alarm.
// Does not depend on rtca_pkg; the field widths are written out here.
`timescale 1ns / 1ps

interface rtca_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [4:0]  offset;
  logic [31:0] write_data;

  modport source (output valid, output op, output offset, output write_data, input ready);
  modport sink   (input valid, input op, input offset, input write_data, output ready);
endinterface

interface rtca_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq;
  logic        bad_access;

  modport source (output valid, output read_data, output irq, output bad_access, input ready);
  modport sink   (input valid, input read_data, input irq, input bad_access, output ready);
endinterface

>>> sv/rtca_in_stage.sv
// Input register of the real-time counter with alarm.
// Captures one item per transfer; depends on rtca_pkg.
`timescale 1ns / 1ps

module rtca_in_stage
  import rtca_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  rtca_item_t in_item,
  input  logic       advance,
  output logic       item_valid,
  output rtca_item_t item
);

  logic       valid_r;
  logic       valid_nxt;
  rtca_item_t item_r;

  // The register may refill in the same cycle that its item moves on.
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

>>> sv/rtca_core.sv
// Register file and update logic of the real-time counter with alarm.
// Applies one item per enabled cycle and forms its result; depends on rtca_pkg.
`timescale 1ns / 1ps

module rtca_core
  import rtca_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         advance,
  input  rtca_item_t   item,
  output rtca_result_t result
);

  logic [31:0] mode_r,  mode_nxt;
  logic [31:0] alarm_r, alarm_nxt;
  logic [31:0] cnt_r,   cnt_nxt;
  logic [1:0]  stat_r,  stat_nxt;

  logic [31:0] cnt_pre;
  logic [1:0]  stat_pre;
  logic        run_upd;
  logic [31:0] rdata;
  logic        bad;

  always_comb begin
    mode_nxt  = mode_r;
    alarm_nxt = alarm_r;
    cnt_pre   = cnt_r;
    stat_pre  = stat_r;
    run_upd   = 1'b0;
    rdata     = 32'd0;
    bad       = 1'b0;
    unique case (item.op)
      OP_TICK: begin
        cnt_pre                = cnt_r + 32'd1;
        stat_pre[STAT_INC_BIT] = 1'b1;
        run_upd                = 1'b1;
      end
      OP_READ: begin
        unique case (item.offset)
          OFF_MODE:   rdata = mode_r;
          OFF_ALARM:  rdata = alarm_r;
          OFF_VALUE:  rdata = cnt_r;
          OFF_STATUS: begin
            rdata    = {30'd0, stat_r};
            stat_pre = 2'b00;
          end
          default:    bad = 1'b1;
        endcase
      end
      OP_WRITE: begin
        unique case (item.offset)
          OFF_MODE: begin
            mode_nxt = item.write_data;
            run_upd  = 1'b1;
          end
          OFF_ALARM: begin
            alarm_nxt = item.write_data;
            run_upd   = 1'b1;
          end
          default: bad = 1'b1;
        endcase
      end
      default: ;
    endcase

    // Update step: the new mode and alarm words take effect at once.
    cnt_nxt = (run_upd && mode_nxt[MODE_CNT_RESET_BIT]) ? 32'd0 : cnt_pre;
    stat_nxt = stat_pre;
    if (run_upd && (cnt_nxt == alarm_nxt)) begin
      stat_nxt[STAT_ALARM_BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RESET;
      alarm_r <= ALARM_RESET;
      cnt_r   <= 32'd0;
      stat_r  <= 2'b00;
    end else if (advance) begin
      mode_r  <= mode_nxt;
      alarm_r <= alarm_nxt;
      cnt_r   <= cnt_nxt;
      stat_r  <= stat_nxt;
    end
  end

  assign result.read_data  = rdata;
  assign result.irq        = |stat_nxt;
  assign result.bad_access = bad;

endmodule

>>> sv/rtca_out_stage.sv
// Result register of the real-time counter with alarm.
// Holds one result until its transfer; depends on rtca_pkg.
`timescale 1ns / 1ps

module rtca_out_stage
  import rtca_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         load,
  input  rtca_result_t result,
  output logic         free,
  output logic         out_valid,
  input  logic         out_ready,
  output rtca_result_t out_result
);

  logic         valid_r;
  logic         valid_nxt;
  rtca_result_t result_r;

  assign free      = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

>>> sv/real_time_counter_alarm.sv
// Top level of the real-time counter with alarm.
// Instantiates rtca_in_stage, rtca_core and rtca_out_stage; uses rtca_pkg and rtca_ifs.
//
//   Channel   Dir  Handshake          Payload
//   in_chan   in   valid / ready      op[1:0], offset[4:0], write_data[31:0]
//   out_chan  out  valid / ready      read_data[31:0], irq, bad_access
//
// An item moves from the input register through the register update into the result
// register. One item per clock is sustained while out_chan is ready; the counter and
// status registers update as the item leaves the input register.
// Reset (rst_n low, synchronous) empties both stages and loads the register reset values.
// A stalled result holds the item behind it; in_chan ready drops only when both are full.
`timescale 1ns / 1ps

module real_time_counter_alarm
  import rtca_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  rtca_in_if.sink    in_chan,
  rtca_out_if.source out_chan
);

  rtca_item_t   in_item;
  rtca_item_t   item;
  logic         item_valid;
  rtca_result_t result;
  rtca_result_t out_result;
  logic         out_free;
  logic         advance;

  assign in_item.op         = in_chan.op;
  assign in_item.offset     = in_chan.offset;
  assign in_item.write_data = in_chan.write_data;

  assign advance = item_valid && out_free;

  rtca_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  rtca_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .advance(advance),
    .item   (item),
    .result (result)
  );

  rtca_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result     (result),
    .free       (out_free),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_result (out_result)
  );

  assign out_chan.read_data  = out_result.read_data;
  assign out_chan.irq        = out_result.irq;
  assign out_chan.bad_access = out_result.bad_access;

endmodule
